// File: hw/rtl/tboq_pkg.sv
// ----------------------------------------------------------------------------
// tboq_pkg
// Shared types and constants for the timestamp byte-offset queue.
// ----------------------------------------------------------------------------
package tboq_pkg;

    // table geometry
    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // field widths
    localparam int BYTE_W = 32;
    localparam int PTS_W  = 64;

    // operation codes
    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_GET   = 2'd1,
        OP_FLUSH = 2'd2
    } t_op;

    // sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_RD,
        S_CMP,
        S_DONE
    } t_state;

    // one stored record
    typedef struct packed {
        logic                    present;
        logic signed [PTS_W-1:0] pts;
        logic [BYTE_W-1:0]       bytes;
    } t_rec;

    localparam int REC_W = $bits(t_rec);

    // result of one walk step
    typedef struct packed {
        logic              fits;
        logic [BYTE_W-1:0] left_next;
    } t_step_res;

endpackage

// File: hw/rtl/tboq_in_if.sv
// ----------------------------------------------------------------------------
// tboq_in_if
// Input channel of the queue: one operation per transaction.
// ----------------------------------------------------------------------------
interface tboq_in_if import tboq_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [1:0]              operation;
    logic [BYTE_W-1:0]       byte_count;
    logic signed [PTS_W-1:0] packet_pts;
    logic                    packet_pts_present;
    logic                    consume_on_match;

    modport source (
        output valid, operation, byte_count, packet_pts, packet_pts_present,
               consume_on_match,
        input  ready
    );
    modport sink (
        input  valid, operation, byte_count, packet_pts, packet_pts_present,
               consume_on_match,
        output ready
    );
endinterface

// File: hw/rtl/tboq_out_if.sv
// ----------------------------------------------------------------------------
// tboq_out_if
// Result channel of the queue: one result per transaction.
// ----------------------------------------------------------------------------
interface tboq_out_if import tboq_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    match_found;
    logic signed [PTS_W-1:0] matched_pts;

    modport source (
        output valid, match_found, matched_pts,
        input  ready
    );
    modport sink (
        input  valid, match_found, matched_pts,
        output ready
    );
endinterface

// File: hw/rtl/timestamp_byte_offset_queue.sv
// ----------------------------------------------------------------------------
// timestamp_byte_offset_queue
// Bounded table of packet records, newest first, with byte-offset lookup.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one operation per transaction: add a record, get the
//   timestamp for a byte offset, or flush. o_out returns exactly one result
//   per input transaction, in order (all zero for add, flush and unused codes).
//   Records live in a circular buffer in one RAM; the head pointer marks the
//   newest record, so add never moves stored records.
// Sequencing:
//   add, flush, unused codes: from accept through the done state to the
//   result register. get: walks k records, k = 1..TABLE_DEPTH (none if
//   empty); each walk step is a RAM read state (S_RD) plus a compare state
//   (S_CMP) through the shared subtractor. Idle is reached as the result
//   loads; a new transaction is accepted only in idle, after the last result.
// Reset:
//   synchronous, active low; the table is empty and no result is pending.
//   RAM contents need no clearing: only entries below the count are read.
// Stall:
//   a finished result waits in the output register; the sequencer holds in
//   its done state until the output register can be loaded.
// ----------------------------------------------------------------------------
module timestamp_byte_offset_queue import tboq_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tboq_in_if.sink    i_in,
    tboq_out_if.source o_out
);

    t_state                  r_state, n_state;
    logic [IDX_W-1:0]        r_head, n_head;
    logic [CNT_W-1:0]        r_count, n_count;
    logic [IDX_W-1:0]        r_ptr, n_ptr;
    logic [CNT_W-1:0]        r_idx, n_idx;
    logic [BYTE_W-1:0]       r_left, n_left;
    logic                    r_consume, n_consume;
    logic                    r_res_found, n_res_found;
    logic signed [PTS_W-1:0] r_res_pts, n_res_pts;
    logic                    r_out_valid, n_out_valid;
    logic                    r_out_found, n_out_found;
    logic signed [PTS_W-1:0] r_out_pts, n_out_pts;

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    t_rec             ram_wdata;
    t_rec             ram_rdata;
    t_step_res        step;
    logic [IDX_W-1:0] head_prev;
    logic [IDX_W-1:0] ptr_next;
    logic [CNT_W-1:0] idx_inc;
    logic             slot_free;

    // record storage
    tboq_ram #(
        .WIDTH (REC_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_ptr),
        .o_rdata (ram_rdata)
    );

    // shared compare and subtract for the walk
    tboq_step_unit u_step (
        .i_left (r_left),
        .i_size (ram_rdata.bytes),
        .o_res  (step)
    );

    // pointer arithmetic with wrap at the table depth
    assign head_prev = (r_head == '0) ? IDX_W'(TABLE_DEPTH - 1) : r_head - IDX_W'(1);
    assign ptr_next  = (r_ptr == IDX_W'(TABLE_DEPTH - 1)) ? '0 : r_ptr + IDX_W'(1);
    assign idx_inc   = r_idx + CNT_W'(1);
    assign slot_free = !r_out_valid || o_out.ready;

    // handshake outputs
    assign i_in.ready        = (r_state == S_IDLE);
    assign o_out.valid       = r_out_valid;
    assign o_out.match_found = r_out_found;
    assign o_out.matched_pts = r_out_pts;

    // sequencer: next state, RAM writes and result
    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_count     = r_count;
        n_ptr       = r_ptr;
        n_idx       = r_idx;
        n_left      = r_left;
        n_consume   = r_consume;
        n_res_found = r_res_found;
        n_res_pts   = r_res_pts;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_found = r_out_found;
        n_out_pts   = r_out_pts;
        ram_we      = 1'b0;
        ram_waddr   = r_ptr;
        ram_wdata   = ram_rdata;

        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_res_found = 1'b0;
                    n_res_pts   = '0;
                    n_state     = S_DONE;
                    case (i_in.operation)
                        OP_ADD: begin
                            ram_we            = 1'b1;
                            ram_waddr         = head_prev;
                            ram_wdata.present = i_in.packet_pts_present;
                            ram_wdata.pts     = i_in.packet_pts;
                            ram_wdata.bytes   = i_in.byte_count;
                            n_head            = head_prev;
                            if (r_count != CNT_W'(TABLE_DEPTH)) begin
                                n_count = r_count + CNT_W'(1);
                            end
                        end
                        OP_GET: begin
                            n_left    = i_in.byte_count;
                            n_consume = i_in.consume_on_match;
                            n_ptr     = r_head;
                            n_idx     = '0;
                            if (r_count != '0) begin
                                n_state = S_RD;
                            end
                        end
                        OP_FLUSH: begin
                            n_count = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_RD: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                if (step.fits) begin
                    n_res_found = ram_rdata.present;
                    n_res_pts   = ram_rdata.present ? ram_rdata.pts : '0;
                    if (r_consume) begin
                        ram_we            = 1'b1;
                        ram_waddr         = r_ptr;
                        ram_wdata.present = 1'b0;
                        ram_wdata.pts     = '0;
                        n_count           = idx_inc;
                    end
                    n_state = S_DONE;
                end else begin
                    n_left  = step.left_next;
                    n_idx   = idx_inc;
                    n_ptr   = ptr_next;
                    n_state = (idx_inc == r_count) ? S_DONE : S_RD;
                end
            end
            S_DONE: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_found = r_res_found;
                    n_out_pts   = r_res_pts;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_ptr       <= n_ptr;
        r_idx       <= n_idx;
        r_left      <= n_left;
        r_consume   <= n_consume;
        r_res_found <= n_res_found;
        r_res_pts   <= n_res_pts;
        r_out_found <= n_out_found;
        r_out_pts   <= n_out_pts;
    end

`ifndef SYNTHESIS
    // record count never exceeds the table depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TABLE_DEPTH))
        else $error("record count above table depth");

    // the walk only compares records below the count
    a_walk_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |-> (r_idx < r_count))
        else $error("walk index past record count");

    // a new result is loaded only from the done state
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("result loaded outside done state");

    // a result without a match carries zero ticks
    a_no_match_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_found) |-> (r_out_pts == '0))
        else $error("nonzero timestamp without match");
`endif

endmodule

// File: hw/rtl/tboq_ram.sv
// ----------------------------------------------------------------------------
// tboq_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module tboq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/tboq_step_unit.sv
// ----------------------------------------------------------------------------
// tboq_step_unit
// Shared subtractor for the offset walk: fit test and remaining offset.
// ----------------------------------------------------------------------------
module tboq_step_unit import tboq_pkg::*; (
    input  logic [BYTE_W-1:0] i_left,
    input  logic [BYTE_W-1:0] i_size,
    output t_step_res         o_res
);

    logic [BYTE_W:0] diff;

    // offset fits when left - size is zero or borrows
    assign diff            = {1'b0, i_left} - {1'b0, i_size};
    assign o_res.fits      = diff[BYTE_W] | (diff == '0);
    assign o_res.left_next = diff[BYTE_W-1:0];

endmodule

// File: dv/tb_timestamp_byte_offset_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_timestamp_byte_offset_queue
// Drives add, get, flush and unused-code transactions into the record table
// and checks every result against a cycle-free model of the table kept in the
// testbench. A short directed run covers the corner cases, and a segmented
// random run follows: fill bursts, lookups aimed at stored records, and noise.
// ----------------------------------------------------------------------------
module tb_timestamp_byte_offset_queue;
    import tboq_pkg::*;

    // model slots: one for planning stimulus, one for live checking
    localparam int PLAN = 0;
    localparam int LIVE = 1;

    // unused operation code, outside the package enum
    localparam logic [1:0] OP_RSVD = 2'd3;

    localparam int RANDOM_OPS = 450;
    localparam int TAIL_CYCLES = 80;

    // one queued operation plus a flag to let the table drain before it
    typedef struct packed {
        logic                    drain_first;
        logic [1:0]              op;
        logic [BYTE_W-1:0]       bytes;
        logic signed [PTS_W-1:0] pts;
        logic                    present;
        logic                    consume;
    } t_tb_op;

    // one lookup result
    typedef struct packed {
        logic                    found;
        logic signed [PTS_W-1:0] pts;
    } t_tb_res;

    logic i_clk;
    logic i_rst_n;

    tboq_in_if  in_if ();
    tboq_out_if out_if ();

    timestamp_byte_offset_queue u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // record tables, newest first
    t_rec        table_rec [2][TABLE_DEPTH];
    int unsigned table_cnt [2] = '{0, 0};

    t_tb_op      queued_ops [$];
    t_tb_res     expected_pts [$];

    int          mismatches = 0;
    bit          in_taken   = 1'b0;
    int unsigned gap_left   = 0;
    int unsigned burst_left = 1;
    logic [6:0]  stall_phase = '0;
    int unsigned stall_pct  = 0;
    t_tb_op      seen_op;
    t_tb_res     want;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // applies one operation to a table copy and returns its result
    function automatic t_tb_res apply_to_table(input int unsigned w, input t_tb_op o);
        t_tb_res           res;
        int unsigned       n;
        logic [BYTE_W-1:0] left;
        bit                done;
        res  = '0;
        n    = table_cnt[w];
        left = o.bytes;
        done = 1'b0;
        case (o.op)
            OP_ADD: begin
                if (n == TABLE_DEPTH) n = TABLE_DEPTH - 1;
                for (int i = n; i > 0; i--) table_rec[w][i] = table_rec[w][i-1];
                table_rec[w][0].bytes   = o.bytes;
                table_rec[w][0].pts     = o.pts;
                table_rec[w][0].present = o.present;
                table_cnt[w] = n + 1;
            end
            OP_GET: begin
                for (int i = 0; i < n; i++) begin
                    if (!done) begin
                        if (left <= table_rec[w][i].bytes) begin
                            done      = 1'b1;
                            res.found = table_rec[w][i].present;
                            res.pts   = table_rec[w][i].present ? table_rec[w][i].pts : '0;
                            if (o.consume) begin
                                table_rec[w][i].present = 1'b0;
                                table_rec[w][i].pts     = '0;
                                table_cnt[w] = i + 1;
                            end
                        end else begin
                            left = left - table_rec[w][i].bytes;
                        end
                    end
                end
            end
            OP_FLUSH: table_cnt[w] = 0;
            default: ;
        endcase
        return res;
    endfunction

    function automatic t_tb_op mk_op(input logic [1:0] op, input logic [BYTE_W-1:0] b,
                                     input logic signed [PTS_W-1:0] p, input logic pr,
                                     input logic c);
        t_tb_op o;
        o = '{drain_first: 1'b0, op: op, bytes: b, pts: p, present: pr, consume: c};
        return o;
    endfunction

    task automatic push_op(input t_tb_op o);
        void'(apply_to_table(PLAN, o));
        queued_ops.push_back(o);
    endtask

    // packet sizes: mostly small, sometimes large or full range
    function automatic logic [BYTE_W-1:0] rand_size();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel < 7) return $urandom_range(0, 64);
        if (sel < 9) return $urandom_range(0, 5000);
        return $urandom;
    endfunction

    function automatic logic signed [PTS_W-1:0] rand_pts();
        int unsigned sel;
        sel = $urandom_range(0, 19);
        if (sel == 0) return {1'b1, {(PTS_W-1){1'b0}}};
        if (sel == 1) return {1'b0, {(PTS_W-1){1'b1}}};
        return {$urandom, $urandom};
    endfunction

    // offset that lands inside a stored record, or just past the last one
    function automatic logic [BYTE_W-1:0] aim_offset();
        longint unsigned acc;
        longint unsigned total;
        int unsigned     k;
        int unsigned     n;
        n     = table_cnt[PLAN];
        acc   = 0;
        total = 0;
        if (n == 0) return $urandom_range(0, 50);
        k = $urandom_range(0, n - 1);
        for (int i = 0; i < n; i++) begin
            if (i < k) acc = acc + table_rec[PLAN][i].bytes;
            total = total + table_rec[PLAN][i].bytes;
        end
        if ($urandom_range(0, 9) < 7)
            acc = acc + $urandom_range(0, table_rec[PLAN][k].bytes);
        else
            acc = total + 1 + $urandom_range(0, 3);
        if (acc > 64'h0000_0000_FFFF_FFFF) return $urandom;
        return acc[BYTE_W-1:0];
    endfunction

    // stimulus, end of run
    initial begin
        int unsigned made;
        int unsigned seg;
        t_tb_op      o;
        in_if.valid              = 1'b0;
        in_if.operation          = OP_ADD;
        in_if.byte_count         = '0;
        in_if.packet_pts         = '0;
        in_if.packet_pts_present = 1'b0;
        in_if.consume_on_match   = 1'b0;
        out_if.ready             = 1'b0;
        i_rst_n                  = 1'b0;
        made = 0;

        // directed: empty table, unused code, field extremes, consume cases
        push_op(mk_op(OP_GET,   32'd0, 64'sd0, 1'b0, 1'b1));
        push_op(mk_op(OP_FLUSH, 32'd0, 64'sd0, 1'b0, 1'b0));
        push_op(mk_op(OP_RSVD,  '1, '1, 1'b1, 1'b1));
        push_op(mk_op(OP_ADD,   32'd0, {1'b1, {(PTS_W-1){1'b0}}}, 1'b1, 1'b0));
        push_op(mk_op(OP_ADD,   '1, {1'b0, {(PTS_W-1){1'b1}}}, 1'b0, 1'b0));
        push_op(mk_op(OP_ADD,   32'd100, -64'sd1, 1'b1, 1'b0));
        push_op(mk_op(OP_GET,   32'd0, 64'sd0, 1'b0, 1'b0));
        push_op(mk_op(OP_GET,   32'd100, 64'sd0, 1'b0, 1'b0));
        push_op(mk_op(OP_GET,   32'd101, 64'sd0, 1'b0, 1'b0));
        push_op(mk_op(OP_GET,   '1, 64'sd0, 1'b0, 1'b0));
        push_op(mk_op(OP_GET,   32'd101, 64'sd0, 1'b0, 1'b1));
        push_op(mk_op(OP_GET,   '1, 64'sd0, 1'b0, 1'b0));
        push_op(mk_op(OP_FLUSH, 32'd0, 64'sd0, 1'b0, 1'b0));
        push_op(mk_op(OP_ADD,   32'd10, 64'sd5, 1'b1, 1'b0));
        push_op(mk_op(OP_ADD,   32'd20, 64'sd7, 1'b1, 1'b0));
        push_op(mk_op(OP_GET,   32'd31, 64'sd0, 1'b0, 1'b0));
        push_op(mk_op(OP_GET,   32'd30, 64'sd0, 1'b0, 1'b0));
        push_op(mk_op(OP_GET,   32'd25, 64'sd0, 1'b0, 1'b1));
        push_op(mk_op(OP_GET,   32'd25, 64'sd0, 1'b0, 1'b0));
        push_op(mk_op(OP_GET,   32'd20, 64'sd0, 1'b0, 1'b1));
        push_op(mk_op(OP_GET,   32'd21, 64'sd0, 1'b0, 1'b0));
        push_op(mk_op(OP_RSVD,  32'd5, 64'sd9, 1'b1, 1'b1));
        push_op(mk_op(OP_GET,   32'd0, 64'sd0, 1'b0, 1'b0));

        // random: fill bursts, aimed lookups and noise
        while (made < RANDOM_OPS) begin
            seg = $urandom_range(0, 9);
            if (seg < 4) begin
                repeat ($urandom_range(2, 20)) begin
                    o = mk_op(OP_ADD, rand_size(), rand_pts(), $urandom_range(0, 3) != 0,
                              1'($urandom_range(0, 1)));
                    o.drain_first = (made == 0) || ($urandom_range(0, 49) == 0);
                    push_op(o);
                    made++;
                end
            end else if (seg < 8) begin
                repeat ($urandom_range(1, 8)) begin
                    o = mk_op(OP_GET, aim_offset(), {$urandom, $urandom},
                              1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0);
                    o.drain_first = (made == 0) || ($urandom_range(0, 49) == 0);
                    push_op(o);
                    made++;
                end
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    o = mk_op(2'($urandom_range(0, 3)), $urandom, {$urandom, $urandom},
                              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                    o.drain_first = (made == 0);
                    push_op(o);
                    made++;
                end
            end
        end

        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (queued_ops.size() != 0 || expected_pts.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("[timestamp_byte_offset_queue] OK");
        end else begin
            $display("[timestamp_byte_offset_queue] ERROR");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(10_000_000);
        $display("[timestamp_byte_offset_queue] ERROR");
        $finish;
    end

    // sender: bursts with random gaps, holds each transaction until taken
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else if (!in_if.valid || in_taken) begin
            in_taken = 1'b0;
            if (gap_left != 0) begin
                gap_left = gap_left - 1;
                in_if.valid <= 1'b0;
            end else if (queued_ops.size() == 0 ||
                         (queued_ops[0].drain_first && expected_pts.size() != 0)) begin
                in_if.valid <= 1'b0;
            end else begin
                in_if.operation          <= queued_ops[0].op;
                in_if.byte_count         <= queued_ops[0].bytes;
                in_if.packet_pts         <= queued_ops[0].pts;
                in_if.packet_pts_present <= queued_ops[0].present;
                in_if.consume_on_match   <= queued_ops[0].consume;
                in_if.valid              <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 12);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                end else begin
                    burst_left = burst_left - 1;
                end
            end
        end
    end

    // receiver: stall rate changes each time the 7-bit stall_phase counter wraps
    always @(negedge i_clk) begin
        stall_phase <= stall_phase + 1'b1;
        if (stall_phase == '0) begin
            case ($urandom_range(0, 4))
                0, 1:    stall_pct = 0;
                2:       stall_pct = 25;
                3:       stall_pct = 60;
                default: stall_pct = 90;
            endcase
        end
        out_if.ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // input transactions feed the model, result transactions are checked
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_if.valid && in_if.ready) begin
                seen_op = mk_op(in_if.operation, in_if.byte_count, in_if.packet_pts,
                                in_if.packet_pts_present, in_if.consume_on_match);
                expected_pts.push_back(apply_to_table(LIVE, seen_op));
                if (queued_ops.size() != 0) queued_ops.delete(0);
                in_taken = 1'b1;
            end
            if (out_if.valid && out_if.ready) begin
                if (expected_pts.size() == 0) begin
                    $display("%0t: unexpected result, found %0b pts %0d", $time,
                             out_if.match_found, out_if.matched_pts);
                    mismatches++;
                end else begin
                    want = expected_pts.pop_front();
                    if (out_if.match_found !== want.found) begin
                        $display("%0t: match_found expected %0b actual %0b", $time,
                                 want.found, out_if.match_found);
                        mismatches++;
                    end
                    if (out_if.matched_pts !== want.pts) begin
                        $display("%0t: matched_pts expected %0d actual %0d", $time,
                                 want.pts, out_if.matched_pts);
                        mismatches++;
                    end
                end
            end
        end
    end

endmodule
